// ===== hdl/tsp_pkg.sv =====
// Shared types and constants for the tagged slot pool.
// Used by tsp_ctrl, tsp_dp and tagged_slot_pool_deferred_free; no dependencies.
`default_nettype none

package tsp_pkg;

    localparam int POOL_SIZE  = 32;
    localparam int TAG_WIDTH  = 32;
    localparam int LIFE_WIDTH = 16;
    localparam int IDX_WIDTH  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

    localparam logic [63:0] LIFE_MAX64 = (64'd1 << LIFE_WIDTH) - 64'd1;

    typedef logic [IDX_WIDTH-1:0]  idx_t;
    typedef logic [TAG_WIDTH-1:0]  tag_val_t;
    typedef logic [LIFE_WIDTH-1:0] life_t;

    // Item modes
    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_FRAME   = 2'd2;

    // Slot states
    localparam logic [1:0] SLOT_FREE  = 2'd0;
    localparam logic [1:0] SLOT_USED  = 2'd1;
    localparam logic [1:0] SLOT_CLEAN = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] tag;
        logic        skip_reclaim;
        logic [4:0]  slot;
        logic [15:0] frame_delay;
    } req_t;

    typedef struct packed {
        logic [4:0] granted_slot;
        logic       reused;
        logic       ok;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch request, clear scan state
        logic scan;      // tag lookup / free search on current slot
        logic age;       // aging step on current slot
        logic grant;     // take recorded free slot, or flag failure
        logic dealloc;   // mark requested slot clean
        logic out_load;  // move result into output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic last;
        logic have_free;
        logic skip;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/tagged_slot_pool_deferred_free.sv =====
// Tagged slot pool with deferred free: controller plus datapath.
// Depends on tsp_pkg, tsp_ctrl and tsp_dp.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one request beat: allocate,
//   release a slot, or run a frame-end aging pass. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one result beat per request.
//   One request is processed at a time; req_ready is high only while idle.
//   Unknown modes go straight to the result; release first marks the slot clean.
//   Frame end ages every slot in turn, one slot aged per cycle.
//   Allocate examines one slot per cycle and stops early on a tag hit; when the
//   pool is exhausted and reclaim is allowed, one aging sweep follows before
//   the grant.
//   req_ready returns the cycle after the result is loaded; the single-slot
//   scan sets throughput.
//   A finished result waits in the output register while the next request
//   is taken and processed; if rsp_ready stays low, the block holds the next
//   result and stops accepting until the register drains.
//   Reset (rst_n, asynchronous) frees all slots, clears life counters and tag
//   valid bits, and empties the output register.
`default_nettype none

module tagged_slot_pool_deferred_free (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire tsp_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output tsp_pkg::rsp_t       rsp
);

    tsp_pkg::cmd_t    cmd;
    tsp_pkg::status_t status;

    tsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_mode  (req.mode),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tsp_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule

`default_nettype wire

// ===== hdl/tsp_dp.sv =====
// Datapath of the tagged slot pool: slot state, life counters, tags and result.
// Depends on tsp_pkg; driven by commands from tsp_ctrl.
`default_nettype none

module tsp_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tsp_pkg::req_t   req,
    input  wire tsp_pkg::cmd_t   cmd,
    output tsp_pkg::status_t     status,
    output tsp_pkg::rsp_t        rsp
);

    logic [1:0]          state_reg [tsp_pkg::POOL_SIZE];
    tsp_pkg::life_t      life_reg  [tsp_pkg::POOL_SIZE];
    logic                tagv_reg  [tsp_pkg::POOL_SIZE];
    tsp_pkg::tag_val_t   tag_mem   [tsp_pkg::POOL_SIZE];
    tsp_pkg::tag_val_t   tag_rd_reg;

    tsp_pkg::idx_t       idx_reg, idx_next;
    logic                free_found_reg, free_found_next;
    tsp_pkg::idx_t       free_idx_reg, free_idx_next;
    tsp_pkg::tag_val_t   tag_reg, tag_next;
    logic                skip_reg, skip_next;
    logic [4:0]          slot_reg, slot_next;
    logic [15:0]         delay_reg, delay_next;
    logic [4:0]          res_slot_reg, res_slot_next;
    logic                res_reused_reg, res_reused_next;
    logic                res_ok_reg, res_ok_next;
    tsp_pkg::rsp_t       out_reg, out_next;

    logic [1:0]          cur_state;
    tsp_pkg::life_t      cur_life;
    logic                cur_tagv;
    tsp_pkg::tag_val_t   cur_tag;
    logic                hit;
    logic                is_last;
    tsp_pkg::life_t      life_inc;
    tsp_pkg::life_t      life_dec;
    logic                age_frees;
    logic                rel_in_range;
    tsp_pkg::idx_t       rel_idx;
    tsp_pkg::life_t      rel_life;

    assign cur_state = state_reg[idx_reg];
    assign cur_life  = life_reg[idx_reg];
    assign cur_tagv  = tagv_reg[idx_reg];
    assign cur_tag   = tag_rd_reg;

    assign hit      = (tag_reg != '0) && cur_tagv && (cur_tag == tag_reg);
    assign is_last  = (idx_reg == tsp_pkg::idx_t'(tsp_pkg::POOL_SIZE - 1));
    assign life_inc = (cur_life == '1) ? cur_life : cur_life + 1'b1;
    assign life_dec = (cur_life != '0) ? cur_life - 1'b1 : cur_life;
    assign age_frees = (cur_state == tsp_pkg::SLOT_CLEAN) && (life_dec == '0);

    assign rel_in_range = (int'(slot_reg) < tsp_pkg::POOL_SIZE);
    assign rel_idx      = tsp_pkg::idx_t'(slot_reg);
    assign rel_life     = (64'(delay_reg) > tsp_pkg::LIFE_MAX64) ? '1
                                                                 : tsp_pkg::life_t'(delay_reg);

    assign status.hit       = hit;
    assign status.last      = is_last;
    assign status.have_free = free_found_reg;
    assign status.skip      = skip_reg;

    assign rsp = out_reg;

    always_comb
    begin
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        tag_next        = tag_reg;
        skip_next       = skip_reg;
        slot_next       = slot_reg;
        delay_next      = delay_reg;
        res_slot_next   = res_slot_reg;
        res_reused_next = res_reused_reg;
        res_ok_next     = res_ok_reg;
        out_next        = out_reg;

        if (cmd.load)
        begin
            idx_next        = '0;
            free_found_next = 1'b0;
            free_idx_next   = '0;
            tag_next        = tsp_pkg::tag_val_t'(req.tag);
            skip_next       = req.skip_reclaim;
            slot_next       = req.slot;
            delay_next      = req.frame_delay;
            res_slot_next   = '0;
            res_reused_next = 1'b0;
            res_ok_next     = 1'b1;
        end

        if (cmd.scan)
        begin
            idx_next = is_last ? '0 : idx_reg + 1'b1;
            if (hit)
            begin
                res_slot_next   = 5'(idx_reg);
                res_reused_next = 1'b1;
            end
            else if (cur_state == tsp_pkg::SLOT_FREE && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = idx_reg;
            end
        end

        if (cmd.age)
        begin
            idx_next = is_last ? '0 : idx_reg + 1'b1;
            // record the first slot this pass frees for the retry
            if (age_frees && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = idx_reg;
            end
        end

        if (cmd.grant)
        begin
            if (free_found_reg)
                res_slot_next = 5'(free_idx_reg);
            else
                res_ok_next = 1'b0;
        end

        if (cmd.out_load)
        begin
            out_next.granted_slot = res_slot_reg;
            out_next.reused       = res_reused_reg;
            out_next.ok           = res_ok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tsp_pkg::POOL_SIZE; i++)
            begin
                state_reg[i] <= tsp_pkg::SLOT_FREE;
                life_reg[i]  <= '0;
                tagv_reg[i]  <= 1'b0;
            end
        end
        else if (cmd.scan && hit)
        begin
            state_reg[idx_reg] <= tsp_pkg::SLOT_USED;
            life_reg[idx_reg]  <= life_inc;
        end
        else if (cmd.age && cur_state == tsp_pkg::SLOT_CLEAN)
        begin
            life_reg[idx_reg] <= life_dec;
            if (age_frees)
            begin
                state_reg[idx_reg] <= tsp_pkg::SLOT_FREE;
                tagv_reg[idx_reg]  <= 1'b0;
            end
        end
        else if (cmd.grant && free_found_reg)
        begin
            state_reg[free_idx_reg] <= tsp_pkg::SLOT_USED;
            if (tag_reg != '0)
                tagv_reg[free_idx_reg] <= 1'b1;
        end
        else if (cmd.dealloc && rel_in_range)
        begin
            state_reg[rel_idx] <= tsp_pkg::SLOT_CLEAN;
            life_reg[rel_idx]  <= rel_life;
        end
    end

    // Tag store: written only on a tagged grant, read only behind its valid bit.
    // Fetch the tag of the slot the scan looks at next.
    always_ff @(posedge clk)
    begin
        if (cmd.grant && free_found_reg && tag_reg != '0)
            tag_mem[free_idx_reg] <= tag_reg;
        tag_rd_reg <= tag_mem[idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end
        else
        begin
            idx_reg        <= idx_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg        <= tag_next;
        skip_reg       <= skip_next;
        slot_reg       <= slot_next;
        delay_reg      <= delay_next;
        res_slot_reg   <= res_slot_next;
        res_reused_reg <= res_reused_next;
        res_ok_reg     <= res_ok_next;
        out_reg        <= out_next;
    end

endmodule

`default_nettype wire

// ===== hdl/tsp_ctrl.sv =====
// Controller of the tagged slot pool: request sequencing and output handshake.
// Depends on tsp_pkg; commands tsp_dp and reads its status.
`default_nettype none

module tsp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic [1:0]        req_mode,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    input  wire tsp_pkg::status_t  status,
    output tsp_pkg::cmd_t          cmd
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_SCAN    = 8'b0000_0010,
        ST_TRY     = 8'b0000_0100,
        ST_RECLAIM = 8'b0000_1000,
        ST_FINAL   = 8'b0001_0000,
        ST_AGE     = 8'b0010_0000,
        ST_RELEASE = 8'b0100_0000,
        ST_FINISH  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.load   = accept;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_mode)
                        tsp_pkg::MODE_ALLOC:   state_next = ST_SCAN;
                        tsp_pkg::MODE_RELEASE: state_next = ST_RELEASE;
                        tsp_pkg::MODE_FRAME:   state_next = ST_AGE;
                        default:               state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.hit)
                    state_next = ST_FINISH;
                else if (status.last)
                    state_next = ST_TRY;
            end
            ST_TRY:
            begin
                // no free slot and reclaim allowed: age once; otherwise grant
                if (status.have_free || status.skip)
                begin
                    cmd.grant  = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_RECLAIM;
                end
            end
            ST_RECLAIM:
            begin
                cmd.age = 1'b1;
                if (status.last)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                cmd.grant  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_AGE:
            begin
                cmd.age = 1'b1;
                if (status.last)
                    state_next = ST_FINISH;
            end
            ST_RELEASE:
            begin
                cmd.dealloc = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (rsp_ready)
            valid_next = 1'b0;
        if (cmd.out_load)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire
